// ===== sv/rbsor_pkg.sv =====
// Shared types, codes and defaults for the red-black relaxation grid sweep.
`default_nettype none
package rbsor_pkg;

	localparam int DEF_MAX_ROWS   = 32;
	localparam int DEF_MAX_COLS   = 32;
	localparam int DEF_VALUE_BITS = 32;

	localparam int WEIGHT_BITS = 18;
	localparam int FRAC_BITS   = 16;
	localparam int FIELD_BITS  = 6;
	localparam int SWEEP_BITS  = 16;
	localparam int OUT_BITS    = 32;
	localparam int IN_DATA_BITS = 136;

	// Item kinds carried on the input tuser.
	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_RUN  = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_ROWS   = 2'd0;
	localparam logic [1:0] CFG_COLS   = 2'd1;
	localparam logic [1:0] CFG_SWEEPS = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_CELL,
		ST_DONE
	} state_t;

	// Per-cell step numbers of the shared multiply-accumulate unit.
	localparam logic [2:0] STEP_FIRST  = 3'd0;
	localparam logic [2:0] STEP_MUL_UP = 3'd1;
	localparam logic [2:0] STEP_MUL_DN = 3'd2;
	localparam logic [2:0] STEP_MUL_LF = 3'd3;
	localparam logic [2:0] STEP_MUL_RT = 3'd4;
	localparam logic [2:0] STEP_OLD    = 3'd5;
	localparam logic [2:0] STEP_RELAX  = 3'd6;
	localparam logic [2:0] STEP_WRITE  = 3'd7;

	// Control from the sequencer to the arithmetic unit.
	typedef struct packed {
		logic mul_en;
		logic mul_update;
		logic acc_clr;
		logic acc_add;
		logic old_ld;
	} mac_ctrl_t;

endpackage
`default_nettype wire

// ===== sv/rbsor_mac.sv =====
// Shared multiply-accumulate unit: rounded Q16 products, saturating sums and the relaxed update.
`default_nettype none
module rbsor_mac
	import rbsor_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                         clk,
	input  wire mac_ctrl_t                    ctrl,
	input  wire logic signed [VALUE_BITS-1:0] rd_value,
	input  wire logic [WEIGHT_BITS-1:0]       weight,
	output logic signed [VALUE_BITS-1:0]      new_value
);
	localparam int OPW  = VALUE_BITS + 1;
	localparam int PW   = OPW + WEIGHT_BITS + 1;
	localparam int ACCW = VALUE_BITS + 6;
	localparam logic signed [ACCW-1:0] SAT_HI =
		ACCW'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
	localparam logic signed [ACCW-1:0] SAT_LO = -SAT_HI - ACCW'(1);
	localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRAC_BITS - 1));

	logic signed [PW-1:0]         prod_s1;
	logic signed [ACCW-1:0]       acc_q;
	logic signed [VALUE_BITS-1:0] old_q;
	logic signed [OPW-1:0]        mul_a;
	logic signed [OPW-1:0]        diff;
	logic signed [PW-1:0]         rounded_full;
	logic signed [ACCW-1:0]       rounded;
	logic signed [VALUE_BITS-1:0] aux_sat;
	logic signed [ACCW-1:0]       upd_sum;

	function automatic logic signed [VALUE_BITS-1:0] sat_vb(input logic signed [ACCW-1:0] v);
		if (v > SAT_HI) begin
			return SAT_HI[VALUE_BITS-1:0];
		end else if (v < SAT_LO) begin
			return SAT_LO[VALUE_BITS-1:0];
		end
		return v[VALUE_BITS-1:0];
	endfunction

	// Operand selection: a neighbor value, or the difference aux - old.
	always_comb begin
		aux_sat = sat_vb(acc_q);
		diff = OPW'(aux_sat) - OPW'(old_q);
		mul_a = ctrl.mul_update ? diff : OPW'(rd_value);
	end

	// Round half toward plus infinity and scale back to Q16.16.
	always_comb begin
		rounded_full = (prod_s1 + HALF) >>> FRAC_BITS;
		rounded = rounded_full[ACCW-1:0];
		upd_sum = ACCW'(old_q) + rounded;
		new_value = sat_vb(upd_sum);
	end

	// The one multiplier, followed by its register.
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_s1 <= PW'(mul_a) * $signed({1'b0, weight});
		end
	end

	// Neighbor sum and the cell's old value.
	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (ctrl.acc_add) begin
			acc_q <= acc_q + rounded;
		end
		if (ctrl.old_ld) begin
			old_q <= rd_value;
		end
	end

endmodule
`default_nettype wire

// ===== sv/red_black_sor_grid_sweep_top.sv =====
// Top level: stream ports, grid memories and the sweep sequencer around the shared unit.
//
//  Channel   Direction  Content
//  s_*       in         item: tuser = kind, tdata = cell position, value, weights, factor
//  m_*       out        result: tdata = read_value, tuser = run_done
//  cfg_*     in         register writes: rows_in_use, cols_in_use, sweep_count
//
// A load writes the grid memories on acceptance; a read's result passes through the
// memory read register and then the output register. A run visits each updated cell
// once per sweep in one scan state and eight steps, row by row, then posts its result;
// the steps share the one multiplier and one memory read port. An empty run skips the scan.
// Reset clears only control state; the grid memories hold no defined value until loaded.
// The input is ready only while idle with a free output register.
`default_nettype none
module red_black_sor_grid_sweep_top
	import rbsor_pkg::*;
#(
	parameter int MAX_ROWS   = DEF_MAX_ROWS,
	parameter int MAX_COLS   = DEF_MAX_COLS,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	// tdata from bit 0: row[6], col[6], cell_value[32], weight_prev_row[18],
	// weight_next_row[18], weight_prev_col[18], weight_next_col[18], relax_factor[18], zeros[2]
	input  wire logic [IN_DATA_BITS-1:0] s_tdata,
	// tuser: kind[2]
	input  wire logic [1:0]              s_tuser,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	// tdata: read_value[32]
	output logic [OUT_BITS-1:0]          m_tdata,
	// tuser: run_done[1]
	output logic                         m_tuser,
	input  wire logic                    cfg_we,
	input  wire logic [1:0]              cfg_index,
	input  wire logic [SWEEP_BITS-1:0]   cfg_data
);
	localparam int STRIDE = MAX_COLS + 2;
	localparam int CELLS  = (MAX_ROWS + 2) * STRIDE;
	localparam int AW     = $clog2(CELLS);
	localparam int RW     = $clog2(MAX_ROWS + 2);
	localparam int CW     = $clog2(MAX_COLS + 3);
	localparam int COEFW  = 5 * WEIGHT_BITS;

	// Configuration registers.
	logic [FIELD_BITS-1:0] rows_q, cols_q;
	logic [SWEEP_BITS-1:0] sweeps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= FIELD_BITS'(32);
			cols_q <= FIELD_BITS'(32);
			sweeps_q <= SWEEP_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ROWS:   rows_q <= cfg_data[FIELD_BITS-1:0];
				CFG_COLS:   cols_q <= cfg_data[FIELD_BITS-1:0];
				CFG_SWEEPS: sweeps_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Input fields.
	kind_t                  in_kind;
	logic [FIELD_BITS-1:0]  in_row, in_col;
	logic signed [31:0]     in_value;
	logic [COEFW-1:0]       in_coef;
	logic                   in_inside;
	logic [AW-1:0]          in_idx;
	logic                   accept;

	assign in_kind  = kind_t'(s_tuser);
	assign in_row   = s_tdata[5:0];
	assign in_col   = s_tdata[11:6];
	assign in_value = s_tdata[43:12];
	assign in_coef  = s_tdata[133:44];
	assign in_inside = (32'(in_row) <= 32'(MAX_ROWS + 1)) && (32'(in_col) <= 32'(MAX_COLS + 1));
	assign in_idx   = AW'(32'(in_row) * 32'(STRIDE) + 32'(in_col));
	assign accept   = s_tvalid && s_tready;

	// Effective row and column counts.
	logic [RW-1:0] nr;
	logic [CW-1:0] nc;
	assign nr = (32'(rows_q) > 32'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(rows_q);
	assign nc = (32'(cols_q) > 32'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(cols_q);

	// Sequencer state and counters.
	state_t state_q, state_d;
	logic [SWEEP_BITS-1:0] k_q;
	logic                  pass_q;
	logic [RW-1:0]         r_q;
	logic [CW-1:0]         c_q;
	logic [2:0]            step_q;
	logic                  rd_inside_q;
	logic                  col_over, last_row, last_sweep, run_empty;

	assign col_over   = c_q > nc;
	assign last_row   = r_q == nr;
	assign last_sweep = k_q == sweeps_q - SWEEP_BITS'(1);
	assign run_empty  = (sweeps_q == '0) || (nr == '0) || (nc == '0);

	function automatic logic [CW-1:0] first_col(input logic [RW-1:0] r, input logic p);
		return (r[0] ^ p) ? CW'(1) : CW'(2);
	endfunction

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_kind)
						KIND_RUN:  state_d = run_empty ? ST_DONE : ST_SCAN;
						KIND_READ: state_d = ST_READ;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: state_d = ST_IDLE;
			ST_SCAN: begin
				if (!col_over) begin
					state_d = ST_CELL;
				end else if (last_row && pass_q && last_sweep) begin
					state_d = ST_DONE;
				end
			end
			ST_CELL: state_d = (step_q == STEP_WRITE) ? ST_SCAN : ST_CELL;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Grid position and sweep counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			pass_q <= 1'b0;
			r_q <= '0;
			c_q <= '0;
			step_q <= STEP_FIRST;
			rd_inside_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					pass_q <= 1'b0;
					r_q <= RW'(1);
					c_q <= CW'(1);
					step_q <= STEP_FIRST;
					rd_inside_q <= in_inside;
				end
				ST_SCAN: begin
					step_q <= STEP_FIRST;
					if (col_over) begin
						if (!last_row) begin
							r_q <= r_q + RW'(1);
							c_q <= first_col(r_q + RW'(1), pass_q);
						end else if (!pass_q) begin
							pass_q <= 1'b1;
							r_q <= RW'(1);
							c_q <= first_col(RW'(1), 1'b1);
						end else begin
							k_q <= k_q + SWEEP_BITS'(1);
							pass_q <= 1'b0;
							r_q <= RW'(1);
							c_q <= CW'(1);
						end
					end
				end
				ST_CELL: begin
					step_q <= step_q + 3'd1;
					if (step_q == STEP_WRITE) begin
						c_q <= c_q + CW'(2);
					end
				end
				default: ;
			endcase
		end
	end

	// Memory control and arithmetic steps.
	logic [AW-1:0]         cell_idx;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic                  wr_en, coef_rd_en;
	logic [VALUE_BITS-1:0] wr_data;
	mac_ctrl_t             ctrl;
	logic [WEIGHT_BITS-1:0] weight;
	logic [COEFW-1:0]      coef_q;
	logic signed [VALUE_BITS-1:0] rd_q;
	logic signed [VALUE_BITS-1:0] new_value;

	assign cell_idx = AW'(32'(r_q) * 32'(STRIDE) + 32'(c_q));

	function automatic logic signed [VALUE_BITS-1:0] sat_load(input logic signed [31:0] v);
		logic signed [63:0] hi, lo, w;
		hi = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		w = 64'(v);
		if (w > hi) begin
			w = hi;
		end else if (w < lo) begin
			w = lo;
		end
		return w[VALUE_BITS-1:0];
	endfunction

	function automatic logic signed [31:0] sat_out(input logic signed [VALUE_BITS-1:0] v);
		logic signed [63:0] w;
		w = 64'(v);
		if (w > 64'sd2147483647) begin
			w = 64'sd2147483647;
		end else if (w < -64'sd2147483648) begin
			w = -64'sd2147483648;
		end
		return w[31:0];
	endfunction

	always_comb begin
		rd_addr = in_idx;
		wr_addr = in_idx;
		wr_en = 1'b0;
		wr_data = sat_load(in_value);
		coef_rd_en = 1'b0;
		ctrl = '0;
		weight = coef_q[WEIGHT_BITS-1:0];
		case (state_q)
			ST_IDLE: begin
				wr_en = accept && (in_kind == KIND_LOAD) && in_inside;
			end
			ST_CELL: begin
				wr_addr = cell_idx;
				wr_data = new_value;
				case (step_q)
					STEP_FIRST: begin
						rd_addr = cell_idx - AW'(STRIDE);
						coef_rd_en = 1'b1;
						ctrl.acc_clr = 1'b1;
					end
					STEP_MUL_UP: begin
						rd_addr = cell_idx + AW'(STRIDE);
						ctrl.mul_en = 1'b1;
						weight = coef_q[WEIGHT_BITS-1:0];
					end
					STEP_MUL_DN: begin
						rd_addr = cell_idx - AW'(1);
						ctrl.mul_en = 1'b1;
						ctrl.acc_add = 1'b1;
						weight = coef_q[2*WEIGHT_BITS-1:WEIGHT_BITS];
					end
					STEP_MUL_LF: begin
						rd_addr = cell_idx + AW'(1);
						ctrl.mul_en = 1'b1;
						ctrl.acc_add = 1'b1;
						weight = coef_q[3*WEIGHT_BITS-1:2*WEIGHT_BITS];
					end
					STEP_MUL_RT: begin
						rd_addr = cell_idx;
						ctrl.mul_en = 1'b1;
						ctrl.acc_add = 1'b1;
						weight = coef_q[4*WEIGHT_BITS-1:3*WEIGHT_BITS];
					end
					STEP_OLD: begin
						rd_addr = cell_idx;
						ctrl.acc_add = 1'b1;
						ctrl.old_ld = 1'b1;
					end
					STEP_RELAX: begin
						rd_addr = cell_idx;
						ctrl.mul_en = 1'b1;
						ctrl.mul_update = 1'b1;
						weight = coef_q[5*WEIGHT_BITS-1:4*WEIGHT_BITS];
					end
					STEP_WRITE: begin
						rd_addr = cell_idx;
						wr_en = 1'b1;
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// Temperature and coefficient memories.
	logic [VALUE_BITS-1:0] temp_mem [CELLS];
	logic [COEFW-1:0]      coef_mem [CELLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			temp_mem[wr_addr] <= wr_data;
		end
		rd_q <= temp_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept && (in_kind == KIND_LOAD) && in_inside) begin
			coef_mem[in_idx] <= in_coef;
		end
		if (coef_rd_en) begin
			coef_q <= coef_mem[cell_idx];
		end
	end

	rbsor_mac #(
		.VALUE_BITS(VALUE_BITS)
	) u_mac (
		.clk      (clk),
		.ctrl     (ctrl),
		.rd_value (rd_q),
		.weight   (weight),
		.new_value(new_value)
	);

	// Output register.
	logic               out_valid_q;
	logic [OUT_BITS-1:0] out_data_q;
	logic               out_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_READ || state_q == ST_DONE) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			out_data_q <= rd_inside_q ? sat_out(rd_q) : '0;
			out_done_q <= 1'b0;
		end else if (state_q == ST_DONE) begin
			out_data_q <= '0;
			out_done_q <= 1'b1;
		end
	end

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_done_q;

endmodule
`default_nettype wire

// ===== test/tb_red_black_sor_grid_sweep_top.sv =====
// Testbench for the red-black relaxation grid sweep: stream driver, monitor and predictor.
`timescale 1ns / 1ps
module tb_red_black_sor_grid_sweep_top;
	import rbsor_pkg::*;

	localparam int STRIDE = DEF_MAX_COLS + 2;
	localparam int CELLS  = (DEF_MAX_ROWS + 2) * STRIDE;

	typedef struct {
		kind_t       kind;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [31:0] value;
		logic [17:0] wt[5];
	} grid_item_t;

	typedef struct {
		logic [31:0] read_value;
		logic        run_done;
	} grid_result_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_DATA_BITS-1:0] s_tdata;
	logic [1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_BITS-1:0] m_tdata;
	logic m_tuser;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [SWEEP_BITS-1:0] cfg_data;

	red_black_sor_grid_sweep_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predicted grid contents and register copies.
	longint      grid_temp[CELLS];
	logic [17:0] grid_wt[5][CELLS];
	int unsigned rows_cfg;
	int unsigned cols_cfg;
	int unsigned sweeps_cfg;

	grid_item_t   pending_items[$];
	grid_result_t expected_results[$];
	grid_item_t   cur_item;
	int  send_gap;
	int  stall_left;
	bit  send_idle_on;
	bit  recv_idle_on;
	int  mismatches;
	int  results_seen;
	int  runs_seen;
	int  reads_seen;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Q16.16 times Q2.16, rounded half toward plus infinity.
	function automatic longint fix_mul(longint v, logic [17:0] w);
		longint lo;
		longint hi;
		longint wl;
		wl = longint'({46'd0, w});
		lo = v & 64'hFFFF;
		hi = (v - lo) >>> 16;
		return hi * wl + ((lo * wl + 32768) >>> 16);
	endfunction

	function automatic void relax_cell(int r, int c);
		int     idx;
		longint old;
		longint acc;
		idx = r * STRIDE + c;
		old = grid_temp[idx];
		acc = fix_mul(grid_temp[idx - STRIDE], grid_wt[0][idx])
			+ fix_mul(grid_temp[idx + STRIDE], grid_wt[1][idx])
			+ fix_mul(grid_temp[idx - 1], grid_wt[2][idx])
			+ fix_mul(grid_temp[idx + 1], grid_wt[3][idx]);
		acc = sat32(acc);
		grid_temp[idx] = sat32(old + fix_mul(acc - old, grid_wt[4][idx]));
	endfunction

	// Apply one accepted beat to the predicted grid and queue its result.
	function automatic void predict_grid_item(grid_item_t it);
		bit           in_grid;
		int           idx;
		int           nr;
		int           nc;
		int           c;
		grid_result_t res;
		in_grid = it.row <= DEF_MAX_ROWS + 1 && it.col <= DEF_MAX_COLS + 1;
		idx = it.row * STRIDE + it.col;
		case (it.kind)
			KIND_LOAD: begin
				if (in_grid) begin
					grid_temp[idx] = longint'(signed'(it.value));
					for (int k = 0; k < 5; k++) grid_wt[k][idx] = it.wt[k];
				end
			end
			KIND_RUN: begin
				nr = rows_cfg > DEF_MAX_ROWS ? DEF_MAX_ROWS : rows_cfg;
				nc = cols_cfg > DEF_MAX_COLS ? DEF_MAX_COLS : cols_cfg;
				for (int s = 0; s < sweeps_cfg; s++)
					for (int p = 0; p < 2; p++)
						for (int r = 1; r <= nr; r++) begin
							c = ((r + p) & 1) ? 1 : 2;
							for (; c <= nc; c += 2) relax_cell(r, c);
						end
				res.read_value = '0;
				res.run_done = 1'b1;
				expected_results.push_back(res);
			end
			KIND_READ: begin
				res.read_value = in_grid ? 32'(sat32(grid_temp[idx])) : '0;
				res.run_done = 1'b0;
				expected_results.push_back(res);
			end
			default: ;
		endcase
	endfunction

	function automatic int draw_gap(bit on);
		return on ? $urandom_range(0, 5) : 0;
	endfunction

	// Driver: presents queued beats with random gaps between them.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= KIND_LOAD;
			send_gap = 0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) predict_grid_item(cur_item);
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				cur_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= cur_item.kind;
				s_tdata <= {2'b00, cur_item.wt[4], cur_item.wt[3], cur_item.wt[2],
					cur_item.wt[1], cur_item.wt[0], cur_item.value, cur_item.col, cur_item.row};
				send_gap = draw_gap(send_idle_on);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: random back-pressure and in-order comparison.
	always @(posedge clk or negedge arst_n) begin
		grid_result_t want;
		int g;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected result beat: read_value=%h run_done=%b",
							m_tdata, m_tuser);
				end else begin
					want = expected_results.pop_front();
					if (want.run_done) runs_seen++; else reads_seen++;
					if (m_tdata !== want.read_value || m_tuser !== want.run_done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Mismatch: expected read_value=%h run_done=%b, got %h %b",
								want.read_value, want.run_done, m_tdata, m_tuser);
					end
				end
				g = draw_gap(recv_idle_on);
				stall_left = g;
				m_tready <= (g == 0);
			end else if (stall_left > 0) begin
				stall_left--;
				m_tready <= (stall_left == 0);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic grid_item_t make_item(kind_t k, int r, int c, logic [31:0] v, bit wide);
		grid_item_t it;
		it.kind = k;
		it.row = 6'(r);
		it.col = 6'(c);
		it.value = v;
		for (int i = 0; i < 4; i++)
			it.wt[i] = wide ? 18'($urandom) : 18'($urandom_range(0, 16'h4400));
		it.wt[4] = wide ? 18'($urandom) : 18'($urandom_range(0, 18'h20000));
		return it;
	endfunction

	function automatic logic [31:0] mild_value();
		return 32'($signed($urandom_range(0, 32'h0C80_0000)) - 32'sh0640_0000);
	endfunction

	// Wait until the block is idle with nothing outstanding.
	task automatic drain();
		while (pending_items.size() > 0 || s_tvalid || send_gap > 0 ||
				expected_results.size() > 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		case (idx)
			CFG_ROWS:   rows_cfg = val & 6'h3F;
			CFG_COLS:   cols_cfg = val & 6'h3F;
			CFG_SWEEPS: sweeps_cfg = val & 16'hFFFF;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_shape(int r, int c, int s);
		drain();
		write_reg(CFG_ROWS, r);
		write_reg(CFG_COLS, c);
		write_reg(CFG_SWEEPS, s);
	endtask

	// Random traffic: mostly loads and reads inside the grid, some runs and noise.
	task automatic random_phase(int count, int run_pct);
		int pick;
		int n;
		bit wide;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			wide = ($urandom_range(0, 9) == 0);
			if (pick < run_pct)
				pending_items.push_back(make_item(KIND_RUN, 0, 0, $urandom, wide));
			else if (pick < 45)
				pending_items.push_back(make_item(KIND_LOAD, $urandom_range(0, 33),
					$urandom_range(0, 33), wide ? $urandom : mild_value(), wide));
			else if (pick < 90)
				pending_items.push_back(make_item(KIND_READ, $urandom_range(0, 33),
					$urandom_range(0, 33), $urandom, wide));
			else if (pick < 95)
				pending_items.push_back(make_item(KIND_READ, $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom, wide));
			else if (pick < 98) begin
				pending_items.push_back(make_item(KIND_LOAD, $urandom_range(34, 63),
					$urandom_range(0, 63), $urandom, 1'b1));
				n--;
			end else begin
				pending_items.push_back(make_item(KIND_NONE, $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom, 1'b1));
				n--;
			end
			n++;
		end
		while (pending_items.size() > 0) @(posedge clk);
	endtask

	initial begin
		grid_item_t it;
		mismatches = 0;
		results_seen = 0;
		runs_seen = 0;
		reads_seen = 0;
		rows_cfg = 32;
		cols_cfg = 32;
		sweeps_cfg = 1;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_ROWS;
		cfg_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Fill every cell, border included, so no run touches an unwritten entry.
		for (int r = 0; r < DEF_MAX_ROWS + 2; r++)
			for (int c = 0; c < STRIDE; c++)
				pending_items.push_back(make_item(KIND_LOAD, r, c, mild_value(), 1'b0));

		// Directed: extreme values and weights, grid edges, outside positions, unknown kind.
		it = make_item(KIND_LOAD, 1, 1, 32'h7FFF_FFFF, 1'b0);
		it.wt = '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF};
		pending_items.push_back(it);
		it = make_item(KIND_LOAD, 1, 2, 32'h8000_0000, 1'b0);
		it.wt = '{18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF};
		pending_items.push_back(it);
		it = make_item(KIND_LOAD, 2, 1, 32'h0001_0000, 1'b0);
		it.wt = '{18'h0, 18'h0, 18'h0, 18'h0, 18'h0};
		pending_items.push_back(it);
		pending_items.push_back(make_item(KIND_LOAD, 34, 5, 32'h1234_5678, 1'b1));
		pending_items.push_back(make_item(KIND_LOAD, 5, 63, 32'h1234_5678, 1'b1));
		pending_items.push_back(make_item(KIND_NONE, 5, 5, 32'hFFFF_FFFF, 1'b1));
		pending_items.push_back(make_item(KIND_READ, 1, 1, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 1, 2, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 0, 0, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 33, 33, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 5, 33, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 5, 5, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 34, 0, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 63, 63, '0, 1'b0));
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 1, 1, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 16, 17, '0, 1'b0));

		// Zero sweeps, zero sizes, oversized counts and one empty run with a very large sweep count.
		set_shape(5, 7, 0);
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 2, 2, '0, 1'b0));
		set_shape(0, 32, 3);
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		set_shape(32, 0, 2);
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		set_shape(0, 0, 65535);
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		set_shape(63, 63, 1);
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 32, 32, '0, 1'b0));
		set_shape(1, 1, 4);
		pending_items.push_back(make_item(KIND_RUN, 0, 0, '0, 1'b0));
		pending_items.push_back(make_item(KIND_READ, 1, 1, '0, 1'b0));

		// Random phases over a spread of grid shapes and idle patterns.
		for (int ph = 0; ph < 7; ph++) begin
			send_idle_on = (ph % 3 != 1);
			recv_idle_on = (ph % 3 != 2);
			if (ph == 3) set_shape(32, 32, 1);
			else if (ph == 5) set_shape($urandom_range(33, 63), $urandom_range(1, 4), 2);
			else set_shape($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 3));
			random_phase(ph == 3 ? 60 : 40, ph == 3 ? 3 : 6);
		end

		drain();
		repeat (20) @(posedge clk);
		$display("Checked %0d results (%0d runs, %0d reads) over a fully loaded grid,",
			results_seen, runs_seen, reads_seen);
		$display("with zero, full, oversized and random grid shapes and sweep counts.");
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Overall time limit.
	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
